// ===== rtl/rsec_pkg.sv =====
// rsec_pkg: shared types, character codes and constant-divide helpers for the
// range scanner echo checker. Stands alone; every file but rsec_ifs imports it.
package rsec_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_TEXT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 3'd7;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // character codes
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_DONE    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // numeric registers, kept with their decimal quotients
  typedef struct packed {
    logic [13:0] start_step;
    logic [10:0] start_q10;
    logic [7:0]  start_q100;
    logic [4:0]  start_q1000;
    logic [13:0] end_step;
    logic [10:0] end_q10;
    logic [7:0]  end_q100;
    logic [4:0]  end_q1000;
    logic [6:0]  cluster_count;
    logic [3:0]  cluster_q10;
    logic [3:0]  scan_interval;
    logic [6:0]  scan_count;
    logic [3:0]  scans_q10;
    logic [31:0] timeout_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{timeout_ms: TIMEOUT_RESET, default: '0};

  typedef struct packed {
    logic [4:0] char_index;
    logic       scans_zeroed;
  } echo_query_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } echo_exp_t;

  // reciprocal multiplies, exact over the input ranges used
  function automatic logic [10:0] div10_w14(input logic [13:0] v);
    logic [30:0] p;
    p = 31'(v) * 31'd52429;
    return p[29:19];
  endfunction

  function automatic logic [7:0] div100_w14(input logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd10486;
    return p[27:20];
  endfunction

  function automatic logic [4:0] div1000_w14(input logic [13:0] v);
    logic [27:0] p;
    p = 28'(v) * 28'd8389;
    return p[27:23];
  endfunction

  function automatic logic [3:0] div10_w7(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  // lo - 10*hi, where the result is known to be a single digit
  function automatic logic [3:0] rem10(input logic [13:0] lo, input logic [13:0] hi);
    logic [13:0] r;
    r = lo - (hi << 3) - (hi << 1);
    return r[3:0];
  endfunction

  // v mod 10 for v below 20
  function automatic logic [3:0] mod10_small(input logic [4:0] v);
    logic [4:0] r;
    r = (v >= 5'd10) ? v - 5'd10 : v;
    return r[3:0];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return {CH_ZERO[7:4], d};
  endfunction

endpackage

// ===== rtl/rsec_ifs.sv =====
// rsec_ifs: valid/ready channel interfaces for received bytes and status results.
// No dependencies.
interface rsec_rx_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_now;

  modport source (output valid, rx_byte, time_now, input ready);
  modport sink   (input valid, rx_byte, time_now, output ready);
endinterface

interface rsec_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_status;

  modport source (output valid, reply_status, input ready);
  modport sink   (input valid, reply_status, output ready);
endinterface

// ===== rtl/rsec_cfg_regs.sv =====
// rsec_cfg_regs: configuration register file; stores decimal quotients at write.
// Depends on rsec_pkg.
module rsec_cfg_regs #(
  parameter int TAG_MAX_CHARS = 8,
  parameter int TLW           = $clog2(TAG_MAX_CHARS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rsec_pkg::cfg_t                   cfg,
  output logic [8*TAG_MAX_CHARS-1:0]       tag_text,
  output logic [TLW-1:0]                   tag_len
);
  import rsec_pkg::*;

  logic [13:0] step_v;
  logic [6:0]  cnt_v;
  logic [3:0]  len_v;

  assign step_v = cfg_wdata[13:0];
  assign cnt_v  = cfg_wdata[6:0];
  assign len_v  = cfg_wdata[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= CFG_RESET;
      tag_text <= '0;
      tag_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_STEP: begin
          cfg.start_step  <= step_v;
          cfg.start_q10   <= div10_w14(step_v);
          cfg.start_q100  <= div100_w14(step_v);
          cfg.start_q1000 <= div1000_w14(step_v);
        end
        CFG_END_STEP: begin
          cfg.end_step  <= step_v;
          cfg.end_q10   <= div10_w14(step_v);
          cfg.end_q100  <= div100_w14(step_v);
          cfg.end_q1000 <= div1000_w14(step_v);
        end
        CFG_CLUSTER_COUNT: begin
          cfg.cluster_count <= cnt_v;
          cfg.cluster_q10   <= div10_w7(cnt_v);
        end
        CFG_SCAN_INTERVAL: cfg.scan_interval <= cfg_wdata[3:0];
        CFG_SCAN_COUNT: begin
          cfg.scan_count <= cnt_v;
          cfg.scans_q10  <= div10_w7(cnt_v);
        end
        CFG_TAG_TEXT: tag_text <= cfg_wdata[8*TAG_MAX_CHARS-1:0];
        CFG_TAG_LENGTH: begin
          // clamp to the tag storage
          if (len_v > 4'(TAG_MAX_CHARS)) tag_len <= TLW'(TAG_MAX_CHARS);
          else                           tag_len <= TLW'(len_v);
        end
        CFG_TIMEOUT_MS: cfg.timeout_ms <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rsec_echo_gen.sv =====
// rsec_echo_gen: expected echo character for a given echo position.
// Depends on rsec_pkg.
module rsec_echo_gen #(
  parameter int TAG_MAX_CHARS = 8,
  parameter int TLW           = $clog2(TAG_MAX_CHARS + 1)
) (
  input  rsec_pkg::cfg_t               cfg,
  input  logic [8*TAG_MAX_CHARS-1:0]   tag_text,
  input  logic [TLW-1:0]               tag_len,
  input  rsec_pkg::echo_query_t        query,
  output rsec_pkg::echo_exp_t          expect_ch
);
  import rsec_pkg::*;

  logic [3:0] off;

  assign off = query.char_index[3:0];

  always_comb begin
    expect_ch = '{valid: 1'b1, ch: '0};
    if (!query.char_index[4]) begin
      unique case (off)
        4'd0:  expect_ch.ch = CH_M;
        4'd1:  expect_ch.ch = CH_S;
        4'd2:  expect_ch.ch = digit_char(mod10_small(cfg.start_q1000));
        4'd3:  expect_ch.ch = digit_char(rem10(14'(cfg.start_q100), 14'(cfg.start_q1000)));
        4'd4:  expect_ch.ch = digit_char(rem10(14'(cfg.start_q10), 14'(cfg.start_q100)));
        4'd5:  expect_ch.ch = digit_char(rem10(cfg.start_step, 14'(cfg.start_q10)));
        4'd6:  expect_ch.ch = digit_char(mod10_small(cfg.end_q1000));
        4'd7:  expect_ch.ch = digit_char(rem10(14'(cfg.end_q100), 14'(cfg.end_q1000)));
        4'd8:  expect_ch.ch = digit_char(rem10(14'(cfg.end_q10), 14'(cfg.end_q100)));
        4'd9:  expect_ch.ch = digit_char(rem10(cfg.end_step, 14'(cfg.end_q10)));
        4'd10: expect_ch.ch = digit_char(mod10_small(5'(cfg.cluster_q10)));
        4'd11: expect_ch.ch = digit_char(rem10(14'(cfg.cluster_count), 14'(cfg.cluster_q10)));
        4'd12: expect_ch.ch = digit_char(mod10_small(5'(cfg.scan_interval)));
        4'd13: expect_ch.ch = query.scans_zeroed ? CH_ZERO :
                              digit_char(mod10_small(5'(cfg.scans_q10)));
        4'd14: expect_ch.ch = query.scans_zeroed ? CH_ZERO :
                              digit_char(rem10(14'(cfg.scan_count), 14'(cfg.scans_q10)));
        4'd15: expect_ch.ch = CH_SEMI;
        default: ;
      endcase
    end else begin
      // tag characters, then past the end of the text
      expect_ch.valid = {1'b0, off} < 5'(tag_len);
      for (int i = 0; i < TAG_MAX_CHARS; i++) begin
        if (off == 4'(i)) expect_ch.ch = tag_text[8*i +: 8];
      end
    end
  end

endmodule

// ===== rtl/rsec_parser.sv =====
// rsec_parser: reply phase tracker, checksum and timeout logic for one byte.
// Depends on rsec_pkg; takes the expected echo character from rsec_echo_gen.
module rsec_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  logic [7:0]             rx_byte,
  input  logic [31:0]            time_now,
  input  logic [31:0]            timeout_ms,
  input  rsec_pkg::echo_exp_t    expect_ch,
  output rsec_pkg::echo_query_t  query,
  output rsec_pkg::status_t      status_next
);
  import rsec_pkg::*;

  typedef enum logic [2:0] {
    PH_ACK, PH_STATUS_ACK, PH_ECHO, PH_STATUS_ECHO, PH_STAMP, PH_ERROR
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  char_index, char_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  status0, status0_next;
  logic [7:0]  status1, status1_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [7:0]  byte_before_last, byte_before_last_next;
  logic [31:0] start_time, start_time_next;
  logic        timer_started, timer_started_next;
  logic        scans_zeroed, scans_zeroed_next;

  logic        is_lf, echo_hit, collecting, done;
  logic [4:0]  index_inc;
  logic [7:0]  check_ch;
  logic [31:0] elapsed;

  assign query = '{char_index: char_index, scans_zeroed: scans_zeroed};

  assign is_lf     = rx_byte == CH_LF;
  assign echo_hit  = expect_ch.valid && (expect_ch.ch == rx_byte);
  assign index_inc = (char_index == 5'd31) ? char_index : char_index + 5'd1;
  assign check_ch  = {2'b00, running_sum[5:0]} + CH_ZERO;
  assign collecting = (phase == PH_STAMP) ? (char_index < 5'd4) : (char_index < 5'd2);

  always_comb begin
    phase_next            = phase;
    char_index_next       = char_index;
    running_sum_next      = running_sum;
    status0_next          = status0;
    status1_next          = status1;
    start_time_next       = start_time;
    timer_started_next    = timer_started;
    scans_zeroed_next     = scans_zeroed;
    status_next           = ST_BUSY;
    done                  = 1'b0;

    unique case (phase)
      PH_ACK, PH_ECHO: begin
        // in PH_ACK, char_index is already zero whenever the timer has not started
        if (phase == PH_ACK && !timer_started) begin
          start_time_next    = time_now;
          timer_started_next = 1'b1;
        end
        if (is_lf) begin
          timer_started_next = 1'b0;
          phase_next         = (phase == PH_ACK) ? PH_STATUS_ACK : PH_STATUS_ECHO;
          char_index_next    = '0;
          running_sum_next   = '0;
        end else if (!echo_hit) begin
          timer_started_next = 1'b0;
          phase_next         = PH_ERROR;
          char_index_next    = '0;
          running_sum_next   = '0;
        end else begin
          char_index_next = index_inc;
        end
      end
      PH_STATUS_ACK, PH_STATUS_ECHO, PH_STAMP: begin
        if (collecting) begin
          if (char_index == 5'd0) status0_next = rx_byte;
          if (char_index == 5'd1) status1_next = rx_byte;
          running_sum_next = running_sum + rx_byte;
          char_index_next  = char_index + 5'd1;
        end else if (phase == PH_STATUS_ACK) begin
          if (is_lf && last_byte == CH_LF && byte_before_last == check_ch) begin
            char_index_next  = '0;
            running_sum_next = '0;
            if (status0 == CH_ZERO && status1 == CH_ZERO) begin
              scans_zeroed_next = 1'b1;
              phase_next        = PH_ECHO;
            end else begin
              phase_next = PH_ERROR;
            end
          end
        end else if (phase == PH_STATUS_ECHO) begin
          if (is_lf && last_byte == check_ch) begin
            char_index_next  = '0;
            running_sum_next = '0;
            phase_next = (status0 == CH_NINE && status1 == CH_NINE) ? PH_STAMP : PH_ERROR;
          end
        end else if (is_lf) begin
          // stamp checksum is not checked
          status_next = ST_DONE;
          done        = 1'b1;
        end
      end
      default: begin
        if (is_lf && last_byte == CH_LF) begin
          status_next = ST_ERROR;
          done        = 1'b1;
        end
      end
    endcase

    elapsed = time_now - start_time_next;
    if (!done && elapsed > timeout_ms) begin
      status_next = ST_TIMEOUT;
      done        = 1'b1;
    end

    if (done) begin
      phase_next            = PH_ACK;
      char_index_next       = '0;
      running_sum_next      = '0;
      status0_next          = '0;
      status1_next          = '0;
      last_byte_next        = '0;
      byte_before_last_next = '0;
      start_time_next       = '0;
      timer_started_next    = 1'b0;
      scans_zeroed_next     = 1'b0;
    end else begin
      last_byte_next        = rx_byte;
      byte_before_last_next = last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_ACK;
      char_index       <= '0;
      running_sum      <= '0;
      status0          <= '0;
      status1          <= '0;
      last_byte        <= '0;
      byte_before_last <= '0;
      start_time       <= '0;
      timer_started    <= 1'b0;
      scans_zeroed     <= 1'b0;
    end else if (fire) begin
      phase            <= phase_next;
      char_index       <= char_index_next;
      running_sum      <= running_sum_next;
      status0          <= status0_next;
      status1          <= status1_next;
      last_byte        <= last_byte_next;
      byte_before_last <= byte_before_last_next;
      start_time       <= start_time_next;
      timer_started    <= timer_started_next;
      scans_zeroed     <= scans_zeroed_next;
    end
  end

endmodule

// ===== rtl/range_scanner_echo_checker_core.sv =====
// range_scanner_echo_checker_core: top level of the multi-scan reply checker.
// Depends on rsec_pkg, rsec_ifs, rsec_cfg_regs, rsec_echo_gen and rsec_parser.

// Checks a range scanner's reply to a multi-scan command, one received byte
// (with its millisecond time stamp) per transaction on rx, and returns one
// status per byte on res: 0 in progress, 1 echo done, 2 error, 3 timeout.
// The expected echo is "MS", start and end step as four digits, cluster count
// as two, scan interval as one, scan count as two (00 after the first status
// block), ';' and up to TAG_MAX_CHARS tag characters. After any final status
// the checker starts over with the next byte; the registers keep their values.
// Rate: one byte per clock while res takes each status; a byte waits in the input
// register until the result slot is free, then its status enters the result register.
// A single pass of compare, checksum and 32-bit timeout subtract lies between the
// input register and the result register. The result register lets a new byte enter
// while a status still waits to be taken. Configuration is written through cfg_we /
// cfg_index / cfg_wdata while no byte is in flight; decimal quotients of the step and
// count registers are computed once at write time.
module range_scanner_echo_checker_core #(
  parameter int TAG_MAX_CHARS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rsec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rsec_rx_if.sink                          rx,
  rsec_res_if.source                       res
);
  import rsec_pkg::*;

  localparam int TLW = $clog2(TAG_MAX_CHARS + 1);

  cfg_t                      cfg;
  logic [8*TAG_MAX_CHARS-1:0] tag_text;
  logic [TLW-1:0]            tag_len;
  echo_query_t               echo_q;
  echo_exp_t                 echo_exp;
  status_t                   status_next;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [31:0] s1_time;

  logic out_free, advance, rx_take;

  // the result slot frees when empty or being taken this cycle
  assign out_free = !res.valid || res.ready;
  assign advance  = s1_valid && out_free;
  // refuse transactions while in reset
  assign rx.ready = !rst && (!s1_valid || out_free);
  assign rx_take  = rx.valid && rx.ready;

  rsec_cfg_regs #(.TAG_MAX_CHARS(TAG_MAX_CHARS), .TLW(TLW)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .tag_text  (tag_text),
    .tag_len   (tag_len)
  );

  rsec_echo_gen #(.TAG_MAX_CHARS(TAG_MAX_CHARS), .TLW(TLW)) u_echo (
    .cfg       (cfg),
    .tag_text  (tag_text),
    .tag_len   (tag_len),
    .query     (echo_q),
    .expect_ch (echo_exp)
  );

  rsec_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .rx_byte     (s1_byte),
    .time_now    (s1_time),
    .timeout_ms  (cfg.timeout_ms),
    .expect_ch   (echo_exp),
    .query       (echo_q),
    .status_next (status_next)
  );

  // capture a new transaction; hold the current one while the result slot is full
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      s1_byte <= rx.rx_byte;
      s1_time <= rx.time_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res.reply_status <= status_next;
  end

  // a final status always returns the parser to its start
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && status_next != ST_BUSY) |=>
      (echo_q.char_index == 5'd0 && !echo_q.scans_zeroed))
    else $error("parser not cleared after final status");

  // a held byte is neither dropped nor altered while the result slot is full
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_time)))
    else $error("held byte lost");

  // backpressure only when both stages are full
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> (s1_valid && res.valid && !res.ready))
    else $error("rx stalled with room to accept");

endmodule
